FILE: hw/rtl/birc_pkg.sv
// ----------------------------------------------------------------------------
// birc_pkg
// Shared types and constants of the block invert / rotate coder.
// ----------------------------------------------------------------------------
package birc_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    // default and ceiling of the block length
    localparam int BLOCK_MAX_DEFAULT = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 2'd2;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] BLOCK_SIZE_RESET = 6'd8;

    // method and direction codes
    localparam logic METHOD_INVERT = 1'b0;
    localparam logic METHOD_ROTATE = 1'b1;
    localparam logic DIR_ENCODE    = 1'b0;
    localparam logic DIR_DECODE    = 1'b1;

    // inversion patterns
    localparam logic [DATA_W-1:0] MASK_ALL          = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_EVERY_SECOND = 32'hAAAA_AAAA;
    localparam logic [DATA_W-1:0] MASK_EVERY_THIRD  = 32'h2492_4924;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [COUNT_W-1:0] block_size;
        logic               method_select;
        logic               direction;
    } cfg_t;

endpackage

FILE: hw/rtl/birc_in_if.sv
// ----------------------------------------------------------------------------
// birc_in_if
// Plaintext / codetext block channel into the coder.
// ----------------------------------------------------------------------------
interface birc_in_if;
    import birc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  block_bits;
    logic [COUNT_W-1:0] bit_count;
    logic               first_block;

    modport source (output valid, output block_bits, output bit_count,
                    output first_block, input ready);
    modport sink   (input valid, input block_bits, input bit_count,
                    input first_block, output ready);
endinterface

FILE: hw/rtl/birc_out_if.sv
// ----------------------------------------------------------------------------
// birc_out_if
// Coded block channel out of the coder.
// ----------------------------------------------------------------------------
interface birc_out_if;
    import birc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  coded_bits;
    logic [COUNT_W-1:0] out_count;

    modport source (output valid, output coded_bits, output out_count, input ready);
    modport sink   (input valid, input coded_bits, input out_count, output ready);
endinterface

FILE: hw/rtl/block_invert_rotate_coder_core.sv
// ----------------------------------------------------------------------------
// block_invert_rotate_coder_core
// Block coder: per-message inversion patterns or rotate-by-one, encode or
// decode, one block per transfer.
// ----------------------------------------------------------------------------
// One block enters per clock cycle while the output does not stall: an input
// register holds the block, the transform is combinational, and a result
// register presents the coded block on the output channel. The inversion
// pattern of a block depends on the plaintext ones count of the block before
// it; that count is computed and stored in the same cycle as the transform,
// so consecutive blocks follow each other without gaps. Back pressure on the
// output stalls the result register first and then the input register.
// Configuration writes take effect on the next block and are to be made
// while no block is in flight.
module block_invert_rotate_coder_core #(
    parameter int BLOCK_MAX = birc_pkg::BLOCK_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [birc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [birc_pkg::COUNT_W-1:0]      cfg_data,
    birc_in_if.sink                           blk,
    birc_out_if.source                        code
);
    import birc_pkg::*;

    cfg_t               cfg_reg;
    logic [COUNT_W-1:0] prev_ones_reg;

    logic               in_valid_reg;
    logic [DATA_W-1:0]  in_bits_reg;
    logic [COUNT_W-1:0] in_count_reg;
    logic               in_first_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_bits_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [DATA_W-1:0]  xf_bits;
    logic [COUNT_W-1:0] xf_count;
    logic [COUNT_W-1:0] xf_ones;
    logic               out_load;
    logic               in_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_size    <= BLOCK_SIZE_RESET;
            cfg_reg.method_select <= METHOD_INVERT;
            cfg_reg.direction     <= DIR_ENCODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:    cfg_reg.block_size    <= cfg_data;
                CFG_METHOD_SELECT: cfg_reg.method_select <= cfg_data[0];
                CFG_DIRECTION:     cfg_reg.direction     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // stage handshakes
    assign out_load  = in_valid_reg && (!out_valid_reg || code.ready);
    assign in_load   = blk.valid && blk.ready;
    assign blk.ready = !in_valid_reg || out_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (blk.ready)
        begin
            in_valid_reg <= blk.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_bits_reg  <= blk.block_bits;
            in_count_reg <= blk.bit_count;
            in_first_reg <= blk.first_block;
        end
    end

    // transform
    birc_xform #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_xform (
        .cfg         (cfg_reg),
        .prev_ones   (prev_ones_reg),
        .block_bits  (in_bits_reg),
        .bit_count   (in_count_reg),
        .first_block (in_first_reg),
        .coded_bits  (xf_bits),
        .out_count   (xf_count),
        .plain_ones  (xf_ones)
    );

    // previous plaintext ones count, updated as each block leaves the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ones_reg <= '0;
        end
        else if (out_load)
        begin
            prev_ones_reg <= xf_ones;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || code.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bits_reg  <= xf_bits;
            out_count_reg <= xf_count;
        end
    end

    // output transfer
    assign code.valid      = out_valid_reg;
    assign code.coded_bits = out_bits_reg;
    assign code.out_count  = out_count_reg;

endmodule

FILE: hw/rtl/birc_xform.sv
// ----------------------------------------------------------------------------
// birc_xform
// Combinational transform of one block: length clamp, inversion pattern or
// one-position rotation, and the plaintext ones count.
// ----------------------------------------------------------------------------
module birc_xform #(
    parameter int BLOCK_MAX = birc_pkg::BLOCK_MAX_DEFAULT
) (
    input  birc_pkg::cfg_t                      cfg,
    input  logic [birc_pkg::COUNT_W-1:0]        prev_ones,
    input  logic [birc_pkg::DATA_W-1:0]         block_bits,
    input  logic [birc_pkg::COUNT_W-1:0]        bit_count,
    input  logic                                first_block,
    output logic [birc_pkg::DATA_W-1:0]         coded_bits,
    output logic [birc_pkg::COUNT_W-1:0]        out_count,
    output logic [birc_pkg::COUNT_W-1:0]        plain_ones
);
    import birc_pkg::*;

    localparam int CAP = (BLOCK_MAX < DATA_W) ? BLOCK_MAX : DATA_W;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP);

    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] len;
    logic [4:0]         len_m1;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  x;
    logic [DATA_W-1:0]  flip;
    logic [DATA_W-1:0]  y;
    logic [DATA_W-1:0]  plain;
    logic [COUNT_W:0]   twice;

    // effective block size and valid length
    always_comb
    begin
        n = cfg.block_size;
        if (n == '0)
        begin
            n = COUNT_W'(1);
        end
        if (n > CAP_C)
        begin
            n = CAP_C;
        end
        len = bit_count;
        if (len == '0 || len > n)
        begin
            len = n;
        end
        len_m1 = 5'(len - COUNT_W'(1));
    end

    // valid bit mask
    always_comb
    begin
        for (int i = 0; i < DATA_W; i++)
        begin
            mask[i] = (COUNT_W'(i) < len);
        end
    end

    assign x     = block_bits & mask;
    assign twice = {prev_ones, 1'b0};

    // pattern from the previous plaintext ones count
    always_comb
    begin
        if (first_block || twice == {1'b0, n})
        begin
            flip = MASK_ALL;
        end
        else if (twice < {1'b0, n})
        begin
            flip = MASK_EVERY_SECOND;
        end
        else
        begin
            flip = MASK_EVERY_THIRD;
        end
    end

    // coded block
    always_comb
    begin
        if (cfg.method_select == METHOD_INVERT)
        begin
            y = (x ^ flip) & mask;
        end
        else if (cfg.direction == DIR_ENCODE)
        begin
            y = ((x << 1) | (x >> len_m1)) & mask;
        end
        else
        begin
            y = ((x >> 1) | ({{(DATA_W-1){1'b0}}, x[0]} << len_m1)) & mask;
        end
    end

    // ones count of the plaintext side
    assign plain = (cfg.direction == DIR_ENCODE) ? x : y;

    always_comb
    begin
        plain_ones = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            plain_ones = plain_ones + COUNT_W'(plain[i]);
        end
    end

    assign coded_bits = y;
    assign out_count  = len;

endmodule
